FILE: sv/dee_pkg.sv
// shared types, constants and helpers of the delta escape encoder
package dee_pkg;

	localparam int unsigned ValueWidth = 64;
	localparam int unsigned ByteCount  = ValueWidth / 8;
	localparam int unsigned IdxWidth   = 4;
	localparam int unsigned CodeWidth  = 3;

	localparam logic [7:0] ESCAPE_BYTE = 8'd127;
	localparam logic signed [ValueWidth:0] SMALL_MIN = -65'sd127;
	localparam logic signed [ValueWidth:0] SMALL_MAX = 65'sd126;

	// byte index of the final byte of a start item: header plus eight value bytes
	localparam logic [IdxWidth-1:0] START_LAST_IDX = IdxWidth'(ByteCount);

	localparam logic [CodeWidth-1:0] CODE_MIN   = 3'd1;
	localparam logic [CodeWidth-1:0] CODE_MAX   = 3'd4;
	localparam logic [CodeWidth-1:0] CODE_RESET = 3'd4;

	// one classified item waiting to be sent as bytes
	typedef struct packed {
		logic [7:0]            head;
		logic [IdxWidth-1:0]   last_idx;
		logic [ValueWidth-1:0] value;
	} item_t;

	// serializer status seen by the top level
	typedef struct packed {
		logic                busy;
		logic [7:0]          head;
		logic [IdxWidth-1:0] last_idx;
	} stat_t;

	// out-of-range codes clamp to the nearest legal width
	function automatic logic [CodeWidth-1:0] effective_code(input logic [CodeWidth-1:0] code);
		logic [CodeWidth-1:0] res;
		res = code;
		if (code < CODE_MIN) begin
			res = CODE_MIN;
		end else if (code > CODE_MAX) begin
			res = CODE_MAX;
		end
		return res;
	endfunction

endpackage

FILE: sv/delta_escape_encoder_top.sv
// delta escape encoder: signed 64-bit values in, compressed byte stream out
//
// input channel in_valid/in_ready carries sample and start_stream; output
// channel out_valid/out_ready carries out_byte and last_byte, one byte per
// beat, last_byte high on the final byte of each input item.
// config channel cfg_valid/cfg_data sets width_code (cfg_ready is always
// high); write it only while the encoder is idle.
// a start item gives 9 bytes (header, eight value bytes), a small step gives
// one byte, an escape gives the escape byte plus 1, 2, 4 or 8 value bytes.
// the first byte of an item passes the item register, then the output
// register. throughput: one item per cycle while each gives one byte and
// the receiver does not stall; a longer item holds in_ready low until its
// last byte is emitted, set by the single byte-wide output register. the
// next item is taken in the cycle the previous item's last byte goes into
// the output register. when the receiver stalls the output byte holds and a
// full item register stays full, so in_ready drops until the stall clears.
// reset clears the previous value to zero and width_code to 4.
module delta_escape_encoder_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] sample,
	input  logic        start_stream,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  out_byte,
	output logic        last_byte,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_data
);
	import dee_pkg::*;

	logic [ValueWidth-1:0] prev_q;
	logic [CodeWidth-1:0]  width_q;
	logic                  in_beat;
	item_t                 item;
	stat_t                 stat;

	assign cfg_ready = 1'b1;
	assign in_beat   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= CODE_RESET;
		end else if (cfg_valid) begin
			width_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (in_beat) begin
			prev_q <= sample;
		end
	end

	dee_classify u_classify (
		.sample       (sample),
		.start_stream (start_stream),
		.prev         (prev_q),
		.width_code   (width_q),
		.item         (item)
	);

	dee_serializer u_serializer (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (in_beat),
		.item      (item),
		.can_load  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte),
		.stat      (stat)
	);

	a_prev_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat |=> prev_q == $past(sample))
		else $error("previous value not updated by accepted beat");

	a_start_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_beat && start_stream |=> stat.busy && stat.last_idx == START_LAST_IDX
			&& stat.head == 8'(effective_code($past(width_q))))
		else $error("start item not loaded as header plus full value");

	a_empty_takes: assert property (@(posedge clk) disable iff (!arst_n)
		!stat.busy |-> in_ready)
		else $error("empty item register refuses input");

endmodule

FILE: sv/dee_classify.sv
// difference, range check and header selection for one incoming value
module dee_classify (
	input  logic [63:0]          sample,
	input  logic                 start_stream,
	input  logic [63:0]          prev,
	input  logic [2:0]           width_code,
	output dee_pkg::item_t       item
);
	import dee_pkg::*;

	logic [ValueWidth:0]  diff;
	logic                 is_short;
	logic [CodeWidth-1:0] code;

	// exact difference on sign-extended operands, never wraps
	assign diff     = {sample[ValueWidth-1], sample} - {prev[ValueWidth-1], prev};
	assign is_short = ($signed(diff) >= SMALL_MIN) && ($signed(diff) <= SMALL_MAX);
	assign code     = effective_code(width_code);

	always_comb begin
		item.value = sample;
		priority if (start_stream) begin
			item.head     = 8'(code);
			item.last_idx = START_LAST_IDX;
		end else if (is_short) begin
			item.head     = diff[7:0];
			item.last_idx = '0;
		end else begin
			// escape payload is 1, 2, 4 or 8 bytes
			item.head     = ESCAPE_BYTE;
			item.last_idx = IdxWidth'(1) << (code - CODE_MIN);
		end
	end

endmodule

FILE: sv/dee_serializer.sv
// item register and byte output register, one byte per beat
module dee_serializer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            load,
	input  dee_pkg::item_t  item,
	output logic            can_load,
	output logic            out_valid,
	input  logic            out_ready,
	output logic [7:0]      out_byte,
	output logic            last_byte,
	output dee_pkg::stat_t  stat
);
	import dee_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic [IdxWidth-1:0] idx_q;
	logic                out_valid_q;
	logic [7:0]          out_byte_q;
	logic                last_q;

	logic                out_load;
	logic                emit;
	logic                at_last;
	logic [7:0]          val_bytes [ByteCount];
	logic [7:0]          next_byte;

	always_comb begin
		for (int i = 0; i < ByteCount; i++) begin
			val_bytes[i] = item_s1.value[8*i +: 8];
		end
	end

	assign out_load = !out_valid_q || out_ready;
	assign emit     = valid_s1 && out_load;
	assign at_last  = (idx_q == item_s1.last_idx);
	assign can_load = !valid_s1 || (out_load && at_last);
	// index zero is the head byte, value bytes follow little-endian
	assign next_byte = (idx_q == '0) ? item_s1.head
		: val_bytes[$clog2(ByteCount)'(idx_q - IdxWidth'(1))];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (load) begin
			valid_s1 <= 1'b1;
			idx_q    <= '0;
		end else if (emit && at_last) begin
			valid_s1 <= 1'b0;
			idx_q    <= '0;
		end else if (emit) begin
			idx_q <= idx_q + IdxWidth'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_byte_q <= next_byte;
			last_q     <= at_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_byte      = out_byte_q;
	assign last_byte     = last_q;
	assign stat.busy     = valid_s1;
	assign stat.head     = item_s1.head;
	assign stat.last_idx = item_s1.last_idx;

endmodule
